// ===== design/quintic_trajectory_reference_assert.svh =====
// Assertion macros for the checker file of this block.
`ifndef QUINTIC_TRAJECTORY_REFERENCE_ASSERT_SVH
`define QUINTIC_TRAJECTORY_REFERENCE_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define QTR_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Condition that must never be seen outside reset.
`define QTR_ASSERT_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("forbidden condition seen");

`endif

// ===== design/qtr_pkg.sv =====
`default_nettype none
package qtr_pkg;

	localparam int TIME_WIDTH_DEF  = 24;
	localparam int TIME_MAX_WIDTH  = 32;
	localparam int TIME_FRAC_BITS  = 16;
	localparam int WORD_WIDTH      = 64;
	localparam int NUM_COEFFS      = 6;
	localparam int NUM_LANES       = 3;
	localparam int NUM_STEPS       = NUM_COEFFS - 1;
	localparam int CFG_INDEX_WIDTH = 3;

	localparam int LANE_POS = 0;
	localparam int LANE_VEL = 1;
	localparam int LANE_ACC = 2;

	localparam logic signed [WORD_WIDTH-1:0] WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
	localparam logic signed [WORD_WIDTH-1:0] WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

	typedef logic signed [WORD_WIDTH-1:0] qtr_word_t;
	typedef qtr_word_t [NUM_COEFFS-1:0] qtr_lane_t;
	typedef qtr_lane_t [NUM_LANES-1:0] qtr_coef_t;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		CFG_COEFF_0,
		CFG_COEFF_1,
		CFG_COEFF_2,
		CFG_COEFF_3,
		CFG_COEFF_4,
		CFG_COEFF_5,
		CFG_FINISH_TIME,
		CFG_DIRECTION
	} qtr_cfg_idx_t;

	// One classified sample on its way from the front to the evaluator.
	typedef struct packed {
		logic [TIME_MAX_WIDTH-1:0] time_val;
		logic                      hold;
	} qtr_item_t;

	// Saturating signed add of two words.
	function automatic qtr_word_t sat_add(qtr_word_t a, qtr_word_t b);
		logic signed [WORD_WIDTH:0] s;
		s = (WORD_WIDTH+1)'(a) + (WORD_WIDTH+1)'(b);
		if (s[WORD_WIDTH] != s[WORD_WIDTH-1])
			return s[WORD_WIDTH] ? WORD_MIN : WORD_MAX;
		return s[WORD_WIDTH-1:0];
	endfunction

	// Saturating negation: the most negative word maps to the most positive.
	function automatic qtr_word_t sat_neg(qtr_word_t a);
		if (a == WORD_MIN)
			return WORD_MAX;
		return -a;
	endfunction

	// Saturating scale by a small unsigned constant.
	function automatic qtr_word_t sat_scale(qtr_word_t a, logic [4:0] k);
		logic signed [WORD_WIDTH+5:0] ax;
		logic signed [WORD_WIDTH+5:0] kx;
		logic signed [WORD_WIDTH+5:0] p;
		ax = (WORD_WIDTH+6)'(a);
		kx = (WORD_WIDTH+6)'($signed({1'b0, k}));
		p  = ax * kx;
		if (!((&p[WORD_WIDTH+5:WORD_WIDTH-1]) || !(|p[WORD_WIDTH+5:WORD_WIDTH-1])))
			return p[WORD_WIDTH+5] ? WORD_MIN : WORD_MAX;
		return p[WORD_WIDTH-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== design/qtr_front.sv =====
`default_nettype none
module qtr_front #(
	parameter int TIME_WIDTH = qtr_pkg::TIME_WIDTH_DEF
) (
	input  logic                  start,
	input  logic [TIME_WIDTH-1:0] time_now,
	input  logic [TIME_WIDTH-1:0] finish_time,
	input  logic                  queue_full,
	output logic                  busy,
	output logic                  push,
	output qtr_pkg::qtr_item_t    item
);
	import qtr_pkg::*;

	// A sample at or past the finish time is evaluated at the finish time
	// and has its derivatives forced to zero.
	always_comb begin
		busy          = queue_full;
		push          = start && !queue_full;
		item.hold     = (time_now >= finish_time);
		item.time_val = TIME_MAX_WIDTH'(item.hold ? finish_time : time_now);
	end

endmodule
`default_nettype wire

// ===== design/qtr_queue.sv =====
`default_nettype none
module qtr_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  qtr_pkg::qtr_item_t push_item,
	output logic               full,
	output logic               pop,
	output qtr_pkg::qtr_item_t pop_item
);
	import qtr_pkg::*;

	qtr_item_t  slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	// The evaluator takes a beat every cycle, so any held beat leaves at once.
	always_comb begin
		full     = (count_q == 2'd2);
		pop      = (count_q != 2'd0);
		pop_item = slot_q[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_item;
	end

endmodule
`default_nettype wire

// ===== design/qtr_back.sv =====
`default_nettype none
module qtr_back #(
	parameter int TIME_WIDTH = qtr_pkg::TIME_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  qtr_pkg::qtr_item_t in_item,
	input  qtr_pkg::qtr_coef_t coef,
	output logic               done,
	output qtr_pkg::qtr_word_t ref_position,
	output qtr_pkg::qtr_word_t ref_velocity,
	output qtr_pkg::qtr_word_t ref_acceleration
);
	import qtr_pkg::*;

	localparam int LO_W  = 32 + TIME_WIDTH;
	localparam int HI_W  = 33 + TIME_WIDTH;
	localparam int SUM_W = 65 + TIME_WIDTH;
	localparam int SHR_W = SUM_W - TIME_FRAC_BITS;

	logic                  valid_s0;
	logic                  hold_s0;
	logic [TIME_WIDTH-1:0] t_s0;
	qtr_word_t             acc_s0 [NUM_LANES];

	logic                  valid_s1 [NUM_STEPS];
	logic                  hold_s1  [NUM_STEPS];
	logic [TIME_WIDTH-1:0] t_s1     [NUM_STEPS];
	logic [LO_W-1:0]       lo_s1    [NUM_STEPS][NUM_LANES];
	logic signed [HI_W-1:0] hi_s1   [NUM_STEPS][NUM_LANES];

	logic                  valid_s2 [NUM_STEPS];
	logic                  hold_s2  [NUM_STEPS];
	logic [TIME_WIDTH-1:0] t_s2     [NUM_STEPS];
	qtr_word_t             acc_s2   [NUM_STEPS][NUM_LANES];

	logic                  done_q;
	qtr_word_t             pos_q;
	qtr_word_t             vel_q;
	qtr_word_t             acc_q;

	// Entry stage: each lane starts Horner's rule at its top coefficient.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s0 <= 1'b0;
		else
			valid_s0 <= in_valid;
	end

	always_ff @(posedge clk) begin
		hold_s0 <= in_item.hold;
		t_s0    <= in_item.time_val[TIME_WIDTH-1:0];
		for (int l = 0; l < NUM_LANES; l++)
			acc_s0[l] <= coef[l][NUM_COEFFS-1];
	end

	// One Horner step per block: partial products, then shift, saturate, add.
	for (genvar k = 0; k < NUM_STEPS; k++) begin : g_step
		logic                  v_in;
		logic                  h_in;
		logic [TIME_WIDTH-1:0] t_in;

		if (k == 0) begin : g_first
			assign v_in = valid_s0;
			assign h_in = hold_s0;
			assign t_in = t_s0;
		end else begin : g_next
			assign v_in = valid_s2[k-1];
			assign h_in = hold_s2[k-1];
			assign t_in = t_s2[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s1[k] <= 1'b0;
				valid_s2[k] <= 1'b0;
			end else begin
				valid_s1[k] <= v_in;
				valid_s2[k] <= valid_s1[k];
			end
		end

		always_ff @(posedge clk) begin
			hold_s1[k] <= h_in;
			t_s1[k]    <= t_in;
			hold_s2[k] <= hold_s1[k];
			t_s2[k]    <= t_s1[k];
		end

		for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
			qtr_word_t              a_in;
			logic [LO_W-1:0]        lo_d;
			logic signed [HI_W-1:0] hi_d;
			logic signed [SUM_W-1:0] sum;
			logic signed [SHR_W-1:0] shr;
			qtr_word_t              prod;
			qtr_word_t              acc_d;

			if (k == 0) begin : g_first
				assign a_in = acc_s0[l];
			end else begin : g_next
				assign a_in = acc_s2[k-1][l];
			end

			// Split the word into an unsigned low half and a signed high half.
			always_comb begin
				lo_d = LO_W'(a_in[31:0]) * LO_W'(t_in);
				hi_d = HI_W'($signed(a_in[63:32])) * HI_W'($signed({1'b0, t_in}));
			end

			// Floor of the product over the time scale, saturated, plus coefficient.
			always_comb begin
				sum = (SUM_W'(hi_s1[k][l]) << 32) + SUM_W'(lo_s1[k][l]);
				shr = sum[SUM_W-1:TIME_FRAC_BITS];
				if ((&shr[SHR_W-1:WORD_WIDTH-1]) || !(|shr[SHR_W-1:WORD_WIDTH-1]))
					prod = shr[WORD_WIDTH-1:0];
				else
					prod = shr[SHR_W-1] ? WORD_MIN : WORD_MAX;
				acc_d = sat_add(prod, coef[l][NUM_STEPS-1-k]);
			end

			always_ff @(posedge clk) begin
				lo_s1[k][l]  <= lo_d;
				hi_s1[k][l]  <= hi_d;
				acc_s2[k][l] <= acc_d;
			end
		end
	end

	// Output register: derivatives read zero once the trajectory has ended.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= valid_s2[NUM_STEPS-1];
	end

	always_ff @(posedge clk) begin
		pos_q <= acc_s2[NUM_STEPS-1][LANE_POS];
		vel_q <= hold_s2[NUM_STEPS-1] ? '0 : acc_s2[NUM_STEPS-1][LANE_VEL];
		acc_q <= hold_s2[NUM_STEPS-1] ? '0 : acc_s2[NUM_STEPS-1][LANE_ACC];
	end

	assign done             = done_q;
	assign ref_position     = pos_q;
	assign ref_velocity     = vel_q;
	assign ref_acceleration = acc_q;

endmodule
`default_nettype wire

// ===== design/quintic_trajectory_reference.sv =====
`default_nettype none
// Quintic trajectory reference generator.
// Configuration: cfg_we, cfg_index and cfg_data write one register per clock
// edge: coefficients 0 to 5 (signed Q15.48), the finish time (unsigned Q8.16)
// and the direction bit. Write them only while no sample is in flight.
// Input channel: a time sample on time_now is taken at a rising edge where
// start is high and busy is low. busy stays low in operation, so one beat
// can be taken every cycle.
// Result channel: done is high for exactly one cycle with position, velocity
// and acceleration of that sample. The sample passes through the queue
// stage, an entry stage and five Horner steps of two stages each (one
// multiply, one shift-add), then the output register, which drives done.
// Throughput is one sample per cycle.
// Results come out in the order the samples went in. The receiver cannot
// stall, so every result must be taken in the cycle it is shown.
// Reset zeroes control and configuration registers (not data) and empties
// the pipeline; no result is lost or invented by idle cycles on either side.
module quintic_trajectory_reference #(
	parameter int TIME_WIDTH = qtr_pkg::TIME_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [qtr_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic [qtr_pkg::WORD_WIDTH-1:0]       cfg_data,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [TIME_WIDTH-1:0]                time_now,
	output logic                                 done,
	output logic signed [qtr_pkg::WORD_WIDTH-1:0] ref_position,
	output logic signed [qtr_pkg::WORD_WIDTH-1:0] ref_velocity,
	output logic signed [qtr_pkg::WORD_WIDTH-1:0] ref_acceleration
);
	import qtr_pkg::*;

	qtr_word_t             coeff_q [NUM_COEFFS];
	logic [TIME_WIDTH-1:0] finish_q;
	logic                  dir_q;
	qtr_word_t             c_eff [NUM_COEFFS];
	qtr_coef_t             coef_d;
	qtr_coef_t             coef_q;

	logic      queue_full;
	logic      push;
	qtr_item_t push_item;
	logic      pop;
	qtr_item_t pop_item;

	// Configuration registers; every index selects one register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEFFS; i++)
				coeff_q[i] <= '0;
			finish_q <= '0;
			dir_q    <= 1'b0;
		end else if (cfg_we) begin
			case (qtr_cfg_idx_t'(cfg_index))
				CFG_COEFF_0:     coeff_q[0] <= cfg_data;
				CFG_COEFF_1:     coeff_q[1] <= cfg_data;
				CFG_COEFF_2:     coeff_q[2] <= cfg_data;
				CFG_COEFF_3:     coeff_q[3] <= cfg_data;
				CFG_COEFF_4:     coeff_q[4] <= cfg_data;
				CFG_COEFF_5:     coeff_q[5] <= cfg_data;
				CFG_FINISH_TIME: finish_q   <= cfg_data[TIME_WIDTH-1:0];
				CFG_DIRECTION:   dir_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Lane coefficients for position, velocity and acceleration.
	always_comb begin
		c_eff[0] = coeff_q[0];
		for (int i = 1; i < NUM_COEFFS; i++)
			c_eff[i] = dir_q ? sat_neg(coeff_q[i]) : coeff_q[i];
		for (int i = 0; i < NUM_COEFFS; i++)
			coef_d[LANE_POS][i] = c_eff[i];
		coef_d[LANE_VEL][0] = c_eff[1];
		coef_d[LANE_VEL][1] = sat_scale(c_eff[2], 5'd2);
		coef_d[LANE_VEL][2] = sat_scale(c_eff[3], 5'd3);
		coef_d[LANE_VEL][3] = sat_scale(c_eff[4], 5'd4);
		coef_d[LANE_VEL][4] = sat_scale(c_eff[5], 5'd5);
		coef_d[LANE_VEL][5] = '0;
		coef_d[LANE_ACC][0] = sat_scale(c_eff[2], 5'd2);
		coef_d[LANE_ACC][1] = sat_scale(c_eff[3], 5'd6);
		coef_d[LANE_ACC][2] = sat_scale(c_eff[4], 5'd12);
		coef_d[LANE_ACC][3] = sat_scale(c_eff[5], 5'd20);
		coef_d[LANE_ACC][4] = '0;
		coef_d[LANE_ACC][5] = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			coef_q <= '0;
		else
			coef_q <= coef_d;
	end

	qtr_front #(.TIME_WIDTH(TIME_WIDTH)) u_front (
		.start       (start),
		.time_now    (time_now),
		.finish_time (finish_q),
		.queue_full  (queue_full),
		.busy        (busy),
		.push        (push),
		.item        (push_item)
	);

	qtr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (queue_full),
		.pop       (pop),
		.pop_item  (pop_item)
	);

	qtr_back #(.TIME_WIDTH(TIME_WIDTH)) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (pop),
		.in_item          (pop_item),
		.coef             (coef_q),
		.done             (done),
		.ref_position     (ref_position),
		.ref_velocity     (ref_velocity),
		.ref_acceleration (ref_acceleration)
	);

endmodule
`default_nettype wire

// ===== design/qtr_checker.sv =====
`default_nettype none
`include "quintic_trajectory_reference_assert.svh"
module qtr_checker #(
	parameter int TIME_WIDTH = qtr_pkg::TIME_WIDTH_DEF
) (
	input wire logic                                 clk,
	input wire logic                                 arst_n,
	input wire logic                                 cfg_we,
	input wire logic [qtr_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input wire logic [qtr_pkg::WORD_WIDTH-1:0]       cfg_data,
	input wire logic                                 start,
	input wire logic                                 busy,
	input wire logic [TIME_WIDTH-1:0]                time_now,
	input wire logic                                 done,
	input wire logic signed [qtr_pkg::WORD_WIDTH-1:0] ref_position,
	input wire logic signed [qtr_pkg::WORD_WIDTH-1:0] ref_velocity,
	input wire logic signed [qtr_pkg::WORD_WIDTH-1:0] ref_acceleration
);
	// Edges from an accepting edge to the edge that takes its result.
	localparam int LATENCY = 13;

	// Every accepted beat yields its result after the fixed latency.
	`QTR_ASSERT_IMP(a_accept_done, start && !busy, ##LATENCY done)

	// Every result traces back to a beat accepted exactly that long ago.
	`QTR_ASSERT_IMP(a_done_origin, done, $past(start && !busy && arst_n, LATENCY))

	// The queue drains every cycle, so the front never holds off a beat.
	`QTR_ASSERT_NEVER(a_never_busy, busy)

endmodule

bind quintic_trajectory_reference qtr_checker #(.TIME_WIDTH(TIME_WIDTH)) u_qtr_checker (.*);
`default_nettype wire
